// ===== rtl/dbc_pkg.sv =====
package dbc_pkg;

    // word formats
    localparam int SAMPLE_WIDTH = 32;
    localparam int RESULT_WIDTH = 16;
    localparam int REF_WIDTH    = 32;

    // log2 datapath: Q1.31 mantissa, 24 fraction bits found by squaring
    localparam int MANT_WIDTH = 32;
    localparam int FRAC_BITS  = 24;
    localparam int NORM_WIDTH = (SAMPLE_WIDTH > MANT_WIDTH) ? SAMPLE_WIDTH : MANT_WIDTH;
    localparam int EXP_WIDTH  = $clog2(NORM_WIDTH);
    localparam int LOG_WIDTH  = EXP_WIDTH + FRAC_BITS;
    localparam int DIFF_WIDTH = LOG_WIDTH + 1;

    // scale * log10(2) * 128 * 2^16, rounded
    localparam int                   K_WIDTH     = 26;
    localparam logic [K_WIDTH-1:0]   K_POWER     = K_WIDTH'(25252226);
    localparam logic [K_WIDTH-1:0]   K_AMPLITUDE = K_WIDTH'(50504453);
    localparam int                   ROUND_SHIFT = 40;

    // reset reference is 1.0 in Q16.16, whose log2 is exactly 16
    localparam logic [REF_WIDTH-1:0] REF_RESET_LEVEL = REF_WIDTH'(65536);
    localparam logic [LOG_WIDTH-1:0] REF_RESET_LOG   = LOG_WIDTH'(16) << FRAC_BITS;

    localparam logic signed [RESULT_WIDTH-1:0] RESULT_MIN = {1'b1, {(RESULT_WIDTH-1){1'b0}}};
    localparam logic signed [RESULT_WIDTH-1:0] RESULT_MAX = {1'b0, {(RESULT_WIDTH-1){1'b1}}};

    // register map
    localparam int                         CFG_INDEX_WIDTH     = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REFERENCE_LEVEL = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AMPLITUDE_MODE  = CFG_INDEX_WIDTH'(1);

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] sample;
        logic                    last_in;
    } sample_word_t;

    typedef struct packed {
        logic signed [RESULT_WIDTH-1:0] decibels;
        logic                           zero_input;
        logic                           last_out;
    } result_word_t;

    typedef enum logic [1:0] {
        REF_IDLE,
        REF_DETECT,
        REF_SHIFT,
        REF_SQUARE
    } ref_state_t;

    // position of the leading one
    function automatic logic [EXP_WIDTH-1:0] lead_one(input logic [NORM_WIDTH-1:0] x);
        logic [EXP_WIDTH-1:0] e;
        e = '0;
        for (int i = 0; i < NORM_WIDTH; i++) begin
            if (x[i]) begin
                e = EXP_WIDTH'(i);
            end
        end
        return e;
    endfunction

    // move the leading one to the top and keep a Q1.31 mantissa
    function automatic logic [MANT_WIDTH-1:0] normalize(input logic [NORM_WIDTH-1:0] x,
                                                        input logic [EXP_WIDTH-1:0]  e);
        logic [EXP_WIDTH-1:0]  sh;
        logic [NORM_WIDTH-1:0] y;
        sh = EXP_WIDTH'(NORM_WIDTH - 1) - e;
        y  = x << sh;
        return y[NORM_WIDTH-1 -: MANT_WIDTH];
    endfunction

    // one squaring step: {fraction bit, next mantissa}
    function automatic logic [MANT_WIDTH:0] square_step(input logic [MANT_WIDTH-1:0] m);
        logic [2*MANT_WIDTH-1:0] p;
        p = (2*MANT_WIDTH)'(m) * (2*MANT_WIDTH)'(m);
        if (p[2*MANT_WIDTH-1]) begin
            return {1'b1, p[2*MANT_WIDTH-1:MANT_WIDTH]};
        end else begin
            return {1'b0, p[2*MANT_WIDTH-2:MANT_WIDTH-1]};
        end
    endfunction

endpackage

// ===== rtl/decibel_conversion.sv =====
// decibel conversion: scale * log10(sample / reference) in 1/128 dB steps
//
// input channel s_valid/s_ready/s_data carries one Q16.16 sample and a last
// flag per word; result channel m_valid/m_ready/m_data returns one signed
// 1/128 dB word per input word, in order, with a zero flag and the last flag
// copied through. a zero sample returns the most negative code with the zero
// flag set; a zero reference returns the most positive code.
// config channel cfg_valid/cfg_ready/cfg_index/cfg_data is always ready:
// index 0 sets the reference level, index 1 picks power (0) or amplitude (1).
// write it only while no words are in flight.
// throughput: one word per cycle while s_ready is high. the pipeline is made of
// the 24 squaring stages of the log2 pipeline plus input, detect, normalize,
// subtract, multiply and sum stages, ahead of the result fifo.
// after a reference write s_ready drops while a separate squaring unit
// computes log2 of the new reference.
// reset (aresetn low, synchronous) empties the pipeline and result fifo and
// restores reference 1.0 and power mode; s_ready rises right after.
// the pipeline never stalls: a 32-word result fifo absorbs a stalled receiver
// and s_ready drops once every fifo slot is claimed by a word in flight.
module decibel_conversion (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  dbc_pkg::sample_word_t                s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output dbc_pkg::result_word_t                m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dbc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [dbc_pkg::REF_WIDTH-1:0]        cfg_data
);
    import dbc_pkg::*;

    // multiply split: low half unsigned, high half signed
    localparam int SPLIT_BITS = 16;
    localparam int LO_WIDTH   = SPLIT_BITS + K_WIDTH;
    localparam int HI_WIDTH   = DIFF_WIDTH - SPLIT_BITS + K_WIDTH + 1;
    localparam int PROD_WIDTH = DIFF_WIDTH + K_WIDTH + 1;
    localparam int SHIFT_WIDTH = PROD_WIDTH - ROUND_SHIFT;
    localparam int SAT_WIDTH  = (SHIFT_WIDTH > RESULT_WIDTH) ? SHIFT_WIDTH : RESULT_WIDTH;
    localparam logic [PROD_WIDTH-1:0] ROUND_HALF = PROD_WIDTH'(1) << (ROUND_SHIFT - 1);
    localparam logic signed [SAT_WIDTH-1:0] SAT_MAX = SAT_WIDTH'(RESULT_MAX);
    localparam logic signed [SAT_WIDTH-1:0] SAT_MIN = SAT_WIDTH'(RESULT_MIN);

    // fifo sized to cover every word that can be in the pipeline
    localparam int PIPE_STAGES = FRAC_BITS + 6;
    localparam int FIFO_DEPTH  = 1 << $clog2(PIPE_STAGES + 2);
    localparam int PTR_WIDTH   = $clog2(FIFO_DEPTH);
    localparam int CNT_WIDTH   = $clog2(FIFO_DEPTH + 1);
    localparam int STEP_WIDTH  = $clog2(FRAC_BITS);

    // ------------------------------------------------------------------
    // configuration registers and the reference log2 sequencer
    // ------------------------------------------------------------------
    ref_state_t               ref_state_reg, ref_state_next;
    logic [REF_WIDTH-1:0]     ref_work_reg,  ref_work_next;
    logic [EXP_WIDTH-1:0]     ref_exp_reg,   ref_exp_next;
    logic [FRAC_BITS-1:0]     ref_frac_reg,  ref_frac_next;
    logic [STEP_WIDTH-1:0]    ref_step_reg,  ref_step_next;
    logic [LOG_WIDTH-1:0]     ref_log_reg,   ref_log_next;
    logic                     ref_zero_reg,  ref_zero_next;
    logic                     amp_mode_reg,  amp_mode_next;
    logic [MANT_WIDTH:0]      ref_sq;
    logic                     cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign ref_sq    = square_step(MANT_WIDTH'(ref_work_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_state_reg <= REF_IDLE;
            ref_work_reg  <= REF_RESET_LEVEL;
            ref_exp_reg   <= '0;
            ref_frac_reg  <= '0;
            ref_step_reg  <= '0;
            ref_log_reg   <= REF_RESET_LOG;
            ref_zero_reg  <= 1'b0;
            amp_mode_reg  <= 1'b0;
        end else begin
            ref_state_reg <= ref_state_next;
            ref_work_reg  <= ref_work_next;
            ref_exp_reg   <= ref_exp_next;
            ref_frac_reg  <= ref_frac_next;
            ref_step_reg  <= ref_step_next;
            ref_log_reg   <= ref_log_next;
            ref_zero_reg  <= ref_zero_next;
            amp_mode_reg  <= amp_mode_next;
        end
    end

    always_comb begin
        ref_state_next = ref_state_reg;
        ref_work_next  = ref_work_reg;
        ref_exp_next   = ref_exp_reg;
        ref_frac_next  = ref_frac_reg;
        ref_step_next  = ref_step_reg;
        ref_log_next   = ref_log_reg;
        ref_zero_next  = ref_zero_reg;
        amp_mode_next  = amp_mode_reg;

        unique case (ref_state_reg)
            REF_IDLE: begin
            end
            REF_DETECT: begin
                ref_exp_next   = lead_one(NORM_WIDTH'(ref_work_reg));
                ref_state_next = REF_SHIFT;
            end
            REF_SHIFT: begin
                ref_work_next  = REF_WIDTH'(normalize(NORM_WIDTH'(ref_work_reg), ref_exp_reg));
                ref_frac_next  = '0;
                ref_step_next  = '0;
                ref_state_next = REF_SQUARE;
            end
            REF_SQUARE: begin
                ref_work_next = REF_WIDTH'(ref_sq[MANT_WIDTH-1:0]);
                ref_frac_next = {ref_frac_reg[FRAC_BITS-2:0], ref_sq[MANT_WIDTH]};
                ref_step_next = ref_step_reg + STEP_WIDTH'(1);
                if (ref_step_reg == STEP_WIDTH'(FRAC_BITS - 1)) begin
                    // last fraction bit: publish the new reference log
                    ref_log_next   = {ref_exp_reg, ref_frac_reg[FRAC_BITS-2:0],
                                      ref_sq[MANT_WIDTH]};
                    ref_state_next = REF_IDLE;
                end
            end
            default: begin
                ref_state_next = REF_IDLE;
            end
        endcase

        // register writes; a reference write (re)starts the sequencer
        if (cfg_write) begin
            unique case (cfg_index)
                REG_REFERENCE_LEVEL: begin
                    ref_work_next  = cfg_data;
                    ref_zero_next  = (cfg_data == '0);
                    ref_state_next = REF_DETECT;
                end
                REG_AMPLITUDE_MODE: begin
                    amp_mode_next = cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input credit: words accepted but not yet delivered
    // ------------------------------------------------------------------
    logic                 in_accept, out_accept;
    logic [CNT_WIDTH-1:0] pending_reg, pending_next;

    assign s_ready    = (ref_state_reg == REF_IDLE) && (pending_reg < CNT_WIDTH'(FIFO_DEPTH));
    assign in_accept  = s_valid && s_ready;
    assign out_accept = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (in_accept && !out_accept) begin
            pending_next = pending_reg + CNT_WIDTH'(1);
        end else if (!in_accept && out_accept) begin
            pending_next = pending_reg - CNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // ------------------------------------------------------------------
    // sample log2 pipeline
    // ------------------------------------------------------------------
    // input register
    logic                    in_valid_reg;
    logic [SAMPLE_WIDTH-1:0] in_x_reg;
    logic                    in_last_reg;

    // leading one detect
    logic                    det_valid_reg;
    logic [NORM_WIDTH-1:0]   det_x_reg;
    logic [EXP_WIDTH-1:0]    det_exp_reg;
    logic                    det_zero_reg;
    logic                    det_last_reg;

    // squaring chain, entry 0 is the normalized mantissa
    logic                    sq_valid_reg [0:FRAC_BITS];
    logic [MANT_WIDTH-1:0]   sq_m_reg     [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]    sq_frac_reg  [0:FRAC_BITS];
    logic [EXP_WIDTH-1:0]    sq_exp_reg   [0:FRAC_BITS];
    logic                    sq_zero_reg  [0:FRAC_BITS];
    logic                    sq_last_reg  [0:FRAC_BITS];
    logic [MANT_WIDTH:0]     sq_step      [0:FRAC_BITS-1];

    always_comb begin
        for (int i = 0; i < FRAC_BITS; i++) begin
            sq_step[i] = square_step(sq_m_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            det_valid_reg <= 1'b0;
            for (int i = 0; i <= FRAC_BITS; i++) begin
                sq_valid_reg[i] <= 1'b0;
            end
        end else begin
            in_valid_reg    <= in_accept;
            det_valid_reg   <= in_valid_reg;
            sq_valid_reg[0] <= det_valid_reg;
            for (int i = 0; i < FRAC_BITS; i++) begin
                sq_valid_reg[i+1] <= sq_valid_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        in_x_reg    <= s_data.sample;
        in_last_reg <= s_data.last_in;

        det_x_reg    <= NORM_WIDTH'(in_x_reg);
        det_exp_reg  <= lead_one(NORM_WIDTH'(in_x_reg));
        det_zero_reg <= (in_x_reg == '0);
        det_last_reg <= in_last_reg;

        sq_m_reg[0]    <= normalize(det_x_reg, det_exp_reg);
        sq_frac_reg[0] <= '0;
        sq_exp_reg[0]  <= det_exp_reg;
        sq_zero_reg[0] <= det_zero_reg;
        sq_last_reg[0] <= det_last_reg;

        for (int i = 0; i < FRAC_BITS; i++) begin
            sq_m_reg[i+1]    <= sq_step[i][MANT_WIDTH-1:0];
            sq_frac_reg[i+1] <= {sq_frac_reg[i][FRAC_BITS-2:0], sq_step[i][MANT_WIDTH]};
            sq_exp_reg[i+1]  <= sq_exp_reg[i];
            sq_zero_reg[i+1] <= sq_zero_reg[i];
            sq_last_reg[i+1] <= sq_last_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // log difference, scale multiply, round
    // ------------------------------------------------------------------
    logic                          dif_valid_reg;
    logic signed [DIFF_WIDTH-1:0]  dif_d_reg;
    logic [K_WIDTH-1:0]            dif_k_reg;
    logic                          dif_zero_reg;
    logic                          dif_last_reg;

    logic                          mul_valid_reg;
    logic [LO_WIDTH-1:0]           mul_lo_reg, mul_lo_next;
    logic signed [HI_WIDTH-1:0]    mul_hi_reg, mul_hi_next;
    logic                          mul_zero_reg;
    logic                          mul_last_reg;

    logic                          sum_valid_reg;
    logic signed [SHIFT_WIDTH-1:0] sum_r_reg;
    logic [PROD_WIDTH-1:0]         sum_next;
    logic                          sum_zero_reg;
    logic                          sum_last_reg;

    // d * k as two partial products around the split point
    assign mul_lo_next = LO_WIDTH'(dif_d_reg[SPLIT_BITS-1:0]) * LO_WIDTH'(dif_k_reg);
    assign mul_hi_next = $signed(dif_d_reg[DIFF_WIDTH-1:SPLIT_BITS]) * $signed({1'b0, dif_k_reg});

    // recombine and add one half lsb; the top bits are the floor shift
    assign sum_next = ({{(PROD_WIDTH-HI_WIDTH){mul_hi_reg[HI_WIDTH-1]}}, mul_hi_reg} << SPLIT_BITS)
                    + PROD_WIDTH'(mul_lo_reg) + ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dif_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else begin
            dif_valid_reg <= sq_valid_reg[FRAC_BITS];
            mul_valid_reg <= dif_valid_reg;
            sum_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dif_d_reg    <= DIFF_WIDTH'({sq_exp_reg[FRAC_BITS], sq_frac_reg[FRAC_BITS]})
                      - DIFF_WIDTH'(ref_log_reg);
        dif_k_reg    <= amp_mode_reg ? K_AMPLITUDE : K_POWER;
        dif_zero_reg <= sq_zero_reg[FRAC_BITS];
        dif_last_reg <= sq_last_reg[FRAC_BITS];

        mul_lo_reg   <= mul_lo_next;
        mul_hi_reg   <= mul_hi_next;
        mul_zero_reg <= dif_zero_reg;
        mul_last_reg <= dif_last_reg;

        sum_r_reg    <= $signed(sum_next[PROD_WIDTH-1:ROUND_SHIFT]);
        sum_zero_reg <= mul_zero_reg;
        sum_last_reg <= mul_last_reg;
    end

    // saturate and pick the special cases
    logic signed [SAT_WIDTH-1:0] sat_r;
    result_word_t                res_word;

    assign sat_r = SAT_WIDTH'(sum_r_reg);

    always_comb begin
        res_word.zero_input = sum_zero_reg;
        res_word.last_out   = sum_last_reg;
        if (sum_zero_reg) begin
            res_word.decibels = RESULT_MIN;
        end else if (ref_zero_reg) begin
            res_word.decibels = RESULT_MAX;
        end else if (sat_r > SAT_MAX) begin
            res_word.decibels = RESULT_MAX;
        end else if (sat_r < SAT_MIN) begin
            res_word.decibels = RESULT_MIN;
        end else begin
            res_word.decibels = sat_r[RESULT_WIDTH-1:0];
        end
    end

    // ------------------------------------------------------------------
    // result fifo
    // ------------------------------------------------------------------
    result_word_t          fifo_mem_reg [FIFO_DEPTH];
    logic [PTR_WIDTH-1:0]  fifo_wr_reg, fifo_wr_next;
    logic [PTR_WIDTH-1:0]  fifo_rd_reg, fifo_rd_next;
    logic [CNT_WIDTH-1:0]  fifo_count_reg, fifo_count_next;

    always_comb begin
        fifo_wr_next    = fifo_wr_reg;
        fifo_rd_next    = fifo_rd_reg;
        fifo_count_next = fifo_count_reg;
        if (sum_valid_reg) begin
            fifo_wr_next = fifo_wr_reg + PTR_WIDTH'(1);
        end
        if (out_accept) begin
            fifo_rd_next = fifo_rd_reg + PTR_WIDTH'(1);
        end
        if (sum_valid_reg && !out_accept) begin
            fifo_count_next = fifo_count_reg + CNT_WIDTH'(1);
        end else if (!sum_valid_reg && out_accept) begin
            fifo_count_next = fifo_count_reg - CNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_wr_reg    <= '0;
            fifo_rd_reg    <= '0;
            fifo_count_reg <= '0;
        end else begin
            fifo_wr_reg    <= fifo_wr_next;
            fifo_rd_reg    <= fifo_rd_next;
            fifo_count_reg <= fifo_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_valid_reg) begin
            fifo_mem_reg[fifo_wr_reg] <= res_word;
        end
    end

    assign m_valid = (fifo_count_reg != '0);
    assign m_data  = fifo_mem_reg[fifo_rd_reg];

endmodule

// ===== rtl/dbc_checker.sv =====
module dbc_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input dbc_pkg::result_word_t                m_data,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic [dbc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index
);
    import dbc_pkg::*;

    // a zero sample always comes out pinned to the bottom code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_input |-> m_data.decibels == RESULT_MIN)
        else $error("zero flag without minimum result");

    // a new reference blocks input while its log is computed
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && cfg_index == REG_REFERENCE_LEVEL |=> !s_ready)
        else $error("input accepted during reference update");

    // reset leaves no result behind and opens the input
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("state left after reset");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

endmodule

bind decibel_conversion dbc_checker u_dbc_checker (.*);

// ===== sim/decibel_conversion_test.sv =====
`timescale 1ns / 100ps

module decibel_conversion_test;
    import dbc_pkg::*;

    // indexes that map to no register, writes there must be dropped
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_2 = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_3 = CFG_INDEX_WIDTH'(3);

    localparam int NUM_DIRECTED = 33;
    localparam int NUM_PHASES   = 12;
    localparam int PRINT_LIMIT  = 100;

    // how a directed row is used
    typedef enum logic [1:0] {
        ROW_WRITE,      // register write, taken once the pipeline is empty
        ROW_KNOWN,      // sample word with the result typed in
        ROW_PREDICTED   // sample word checked against the predictor
    } row_kind_t;

    // receiver behavior, changed every segment
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_BURSTY
    } rx_style_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic [CFG_INDEX_WIDTH-1:0]     index;
        logic [31:0]                    value;
        logic                           last;
        logic signed [RESULT_WIDTH-1:0] db;
        logic                           zero;
    } step_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    sample_word_t                s_data;
    logic                        m_valid;
    logic                        m_ready;
    result_word_t                m_data;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index;
    logic [REF_WIDTH-1:0]        cfg_data;

    // register copies as the block should hold them
    logic [REF_WIDTH-1:0] ref_level_now = REF_RESET_LEVEL;
    logic                 amplitude_now = 1'b0;

    // results owed by the block, oldest first
    result_word_t awaited_results[$];
    int           mismatches = 0;
    int           burst_left = 0;

    // directed rows: extremes, both scales, zero sample, zero reference,
    // equal sample and reference, writes to unmapped indexes
    step_t directed_steps [NUM_DIRECTED] = '{
        // reset settings: reference 1.0, power
        '{ROW_KNOWN,     '0, 32'h0001_0000, 1'b0, 16'sd0,     1'b0},
        '{ROW_KNOWN,     '0, 32'h0000_0000, 1'b1, RESULT_MIN, 1'b1},
        '{ROW_KNOWN,     '0, 32'h0002_0000, 1'b0, 16'sd385,   1'b0},  // +3 dB
        '{ROW_PREDICTED, '0, 32'h0000_0001, 1'b0, 16'sd0,     1'b0},
        '{ROW_PREDICTED, '0, 32'hFFFF_FFFF, 1'b1, 16'sd0,     1'b0},
        '{ROW_PREDICTED, '0, 32'h8000_0000, 1'b0, 16'sd0,     1'b0},
        '{ROW_PREDICTED, '0, 32'h0001_8000, 1'b0, 16'sd0,     1'b0},
        // amplitude scale
        '{ROW_WRITE, REG_AMPLITUDE_MODE, 32'h0000_0001, 1'b0, 16'sd0, 1'b0},
        '{ROW_KNOWN,     '0, 32'h0002_0000, 1'b0, 16'sd771,   1'b0},  // +6 dB
        '{ROW_KNOWN,     '0, 32'h0001_0000, 1'b0, 16'sd0,     1'b0},
        '{ROW_PREDICTED, '0, 32'hFFFF_FFFF, 1'b0, 16'sd0,     1'b0},
        '{ROW_PREDICTED, '0, 32'h0000_0001, 1'b1, 16'sd0,     1'b0},
        // smallest reference
        '{ROW_WRITE, REG_REFERENCE_LEVEL, 32'h0000_0001, 1'b0, 16'sd0, 1'b0},
        '{ROW_KNOWN,     '0, 32'h0000_0001, 1'b0, 16'sd0,     1'b0},
        '{ROW_PREDICTED, '0, 32'hFFFF_FFFF, 1'b0, 16'sd0,     1'b0},
        '{ROW_KNOWN,     '0, 32'h0000_0000, 1'b0, RESULT_MIN, 1'b1},
        // largest reference
        '{ROW_WRITE, REG_REFERENCE_LEVEL, 32'hFFFF_FFFF, 1'b0, 16'sd0, 1'b0},
        '{ROW_PREDICTED, '0, 32'h0000_0001, 1'b0, 16'sd0,     1'b0},
        '{ROW_KNOWN,     '0, 32'hFFFF_FFFF, 1'b1, 16'sd0,     1'b0},
        // back to power, upper data bits must be ignored
        '{ROW_WRITE, REG_AMPLITUDE_MODE, 32'hFFFF_FFFE, 1'b0, 16'sd0, 1'b0},
        '{ROW_PREDICTED, '0, 32'h0000_0001, 1'b0, 16'sd0,     1'b0},
        '{ROW_PREDICTED, '0, 32'h0001_0000, 1'b0, 16'sd0,     1'b0},
        // zero reference: top code unless the sample is zero
        '{ROW_WRITE, REG_REFERENCE_LEVEL, 32'h0000_0000, 1'b0, 16'sd0, 1'b0},
        '{ROW_KNOWN,     '0, 32'd12345,     1'b0, RESULT_MAX, 1'b0},
        '{ROW_KNOWN,     '0, 32'h0000_0000, 1'b1, RESULT_MIN, 1'b1},
        '{ROW_KNOWN,     '0, 32'hFFFF_FFFF, 1'b0, RESULT_MAX, 1'b0},
        '{ROW_WRITE, REG_UNMAPPED_3, 32'h0000_0001, 1'b0, 16'sd0, 1'b0},
        '{ROW_KNOWN,     '0, 32'h0000_0001, 1'b0, RESULT_MAX, 1'b0},
        // unit reference again, then a dropped write with all ones
        '{ROW_WRITE, REG_REFERENCE_LEVEL, 32'h0001_0000, 1'b0, 16'sd0, 1'b0},
        '{ROW_WRITE, REG_UNMAPPED_2, 32'hFFFF_FFFF, 1'b0, 16'sd0, 1'b0},
        '{ROW_KNOWN,     '0, 32'h0001_0000, 1'b0, 16'sd0,     1'b0},
        '{ROW_PREDICTED, '0, 32'h5A5A_5A5A, 1'b1, 16'sd0,     1'b0},
        '{ROW_PREDICTED, '0, 32'hA5A5_A5A5, 1'b0, 16'sd0,     1'b0}
    };

    decibel_conversion u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // log2 of a nonzero value, 24 fraction bits, by repeated squaring
    function automatic longint log2_scaled(input logic [31:0] x);
        int          e;
        logic [63:0] m;
        logic [23:0] frac;
        e = 0;
        while (e < 31 && (x >> (e + 1)) != 0) begin
            e++;
        end
        m    = 64'(x) << (31 - e);
        frac = '0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            m    = (m * m) >> 31;
            frac = {frac[22:0], 1'b0};
            // mantissa reached 2.0: this fraction bit is set
            if (m[32]) begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        return longint'(e) * (longint'(1) << FRAC_BITS) + longint'(frac);
    endfunction

    // scaled log ratio in 1/128 dB, rounded half up, clamped to the code range
    function automatic result_word_t decibels_of(input sample_word_t word);
        result_word_t res;
        longint       diff;
        longint       gain;
        longint       acc;
        res.last_out   = word.last_in;
        res.zero_input = 1'b0;
        if (word.sample == '0) begin
            res.decibels   = RESULT_MIN;
            res.zero_input = 1'b1;
        end else if (ref_level_now == '0) begin
            res.decibels = RESULT_MAX;
        end else begin
            diff = log2_scaled(word.sample) - log2_scaled(ref_level_now);
            gain = amplitude_now ? longint'(K_AMPLITUDE) : longint'(K_POWER);
            acc  = (diff * gain + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
            if (acc > RESULT_MAX) begin
                acc = RESULT_MAX;
            end else if (acc < RESULT_MIN) begin
                acc = RESULT_MIN;
            end
            res.decibels = acc[RESULT_WIDTH-1:0];
        end
        return res;
    endfunction

    // sample mix: zero, the reference itself, powers of two, wide spread of magnitudes
    function automatic logic [31:0] pick_sample();
        logic [31:0] x;
        case ($urandom_range(0, 9))
            0: x = '0;
            1: x = ref_level_now;
            2: x = 32'h1 << $urandom_range(0, 31);
            3: x = ref_level_now + 32'($urandom_range(0, 6)) - 32'd3;
            4, 5: x = $urandom >> $urandom_range(0, 31);
            6: x = 32'hFFFF_FFFF >> $urandom_range(0, 31);
            default: x = $urandom;
        endcase
        return x;
    endfunction

    // offer one word, hold it until taken, then record what it owes
    task automatic send_word(input sample_word_t word, input result_word_t owed);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= word;
        do @(posedge aclk); while (!s_ready);
        awaited_results.push_back(owed);
    endtask

    // sender idles between bursts of random length
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 45) : $urandom_range(1, 4);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(posedge aclk);
        end
    endtask

    // stop offering and let every owed result come back
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                                  input logic [REF_WIDTH-1:0]       value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == REG_REFERENCE_LEVEL) begin
            ref_level_now = value;
        end else if (index == REG_AMPLITUDE_MODE) begin
            amplitude_now = value[0];
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // 4 ns clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #4ms;
        $display("Some tests failed");
        $finish;
    end

    // receiver: streams, flips a coin, or stalls long enough to fill the result fifo
    initial begin : result_sink
        rx_style_t style;
        int        seg;
        int        on_len;
        int        off_len;
        m_ready = 1'b0;
        forever begin
            style   = rx_style_t'($urandom_range(0, 2));
            seg     = $urandom_range(16, 256);
            on_len  = $urandom_range(1, 12);
            off_len = $urandom_range(1, 48);
            for (int c = 0; c < seg; c++) begin
                @(negedge aclk);
                case (style)
                    RX_STREAM: m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    default:   m_ready <= (c % (on_len + off_len)) < on_len;
                endcase
            end
        end
    end

    // every word taken from the result channel against the oldest owed result
    always @(posedge aclk) begin : result_check
        result_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT) begin
                    $display("%0t: result word with none owed: expected none, got %h",
                             $time, m_data);
                end
            end else begin
                want = awaited_results.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT) begin
                        if (m_data.decibels !== want.decibels) begin
                            $display("%0t: decibels expected %0d, got %0d", $time,
                                     $signed(want.decibels), $signed(m_data.decibels));
                        end
                        if (m_data.zero_input !== want.zero_input) begin
                            $display("%0t: zero_input expected %b, got %b", $time,
                                     want.zero_input, m_data.zero_input);
                        end
                        if (m_data.last_out !== want.last_out) begin
                            $display("%0t: last_out expected %b, got %b", $time,
                                     want.last_out, m_data.last_out);
                        end
                    end
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        step_t        row;
        sample_word_t word;
        result_word_t owed;
        logic [31:0]  level;
        logic         scale;
        int           count;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table under the reset settings first
        foreach (directed_steps[i]) begin
            row = directed_steps[i];
            if (row.kind == ROW_WRITE) begin
                wait_idle();
                write_register(row.index, row.value);
            end else begin
                word.sample  = row.value;
                word.last_in = row.last;
                if (row.kind == ROW_KNOWN) begin
                    owed.decibels   = row.db;
                    owed.zero_input = row.zero;
                    owed.last_out   = row.last;
                end else begin
                    owed = decibels_of(word);
                end
                send_word(word, owed);
                pace();
            end
        end

        // random phases, each under its own reference and scale
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            scale = 1'($urandom_range(0, 1));
            case (p)
                0: begin
                    level = 32'h0000_0001;
                    scale = 1'b1;
                end
                1: begin
                    level = 32'hFFFF_FFFF;
                    scale = 1'b0;
                end
                2: level = '0;
                default: begin
                    case ($urandom_range(0, 3))
                        0: level = REF_RESET_LEVEL;
                        1: level = $urandom;
                        2: level = $urandom >> $urandom_range(0, 31);
                        default: level = 32'h1 << $urandom_range(0, 31);
                    endcase
                end
            endcase
            // mode data carries random upper bits, only bit 0 counts
            write_register(REG_AMPLITUDE_MODE, {31'($urandom), scale});
            write_register(REG_REFERENCE_LEVEL, level);
            if ($urandom_range(0, 3) == 0) begin
                write_register($urandom_range(0, 1) ? REG_UNMAPPED_2 : REG_UNMAPPED_3,
                               $urandom);
            end
            // zero reference pins almost every result, keep that phase short
            count = (p == 2) ? 40 : 160;
            repeat (count) begin
                word.sample  = pick_sample();
                word.last_in = ($urandom_range(0, 7) == 0);
                send_word(word, decibels_of(word));
                pace();
            end
        end

        wait_idle();
        // room for any stray word past the pipeline depth
        repeat (64) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dbc_pkg.sv
rtl/decibel_conversion.sv
rtl/dbc_checker.sv
sim/decibel_conversion_test.sv
